>>> hw/rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Types, constants and fixed-point helpers shared by the escape-time engine.
// ----------------------------------------------------------------------------
package mpe_pkg;

    // Fixed-point format of coordinates and iterates: signed Q4.FRAC_BITS.
    localparam int FRAC_BITS   = 28;
    localparam int VAL_W       = FRAC_BITS + 4;
    localparam int COORD_BITS  = 12;
    localparam int SIZE_W      = 13;
    localparam int STEP_W      = 29;
    localparam int ITER_W      = 16;
    localparam int SAT_W       = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W      = 5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAX_ITER     = 3'd2;
    localparam logic [2:0] REG_OFFSET_X     = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd4;
    localparam logic [2:0] REG_STEP_X       = 3'd5;
    localparam logic [2:0] REG_STEP_Y       = 3'd6;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [VAL_W-2:0]        mag_t;

    typedef struct packed {
        val_t cx;
        val_t cy;
    } point_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [ITER_W-1:0] max_iter;
        val_t              offset_x;
        val_t              offset_y;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
    } cfg_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(VAL_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(VAL_MIN);

    // Clamp a wide exact sum into the Q4 range.
    function automatic val_t sat_val(input logic signed [SAT_W-1:0] v);
        val_t r;
        if (v > SAT_HI)
        begin
            r = VAL_MAX;
        end
        else if (v < SAT_LO)
        begin
            r = VAL_MIN;
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // Scale an exact magnitude product back to Q4 and clamp to the largest value.
    function automatic mag_t fix_mag(input logic [2*VAL_W-1:0] p);
        mag_t r;
        if (|p[2*VAL_W-1:FRAC_BITS+VAL_W-1])
        begin
            r = '1;
        end
        else
        begin
            r = p[FRAC_BITS+VAL_W-2:FRAC_BITS];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/mpe_front.sv
// ----------------------------------------------------------------------------
// mpe_front
// Accepts pixel requests and maps them to points in the complex plane.
// ----------------------------------------------------------------------------
module mpe_front
    import mpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  pt_valid,
    input  logic                  pt_ready,
    output point_t                pt_data
);

    logic   valid_reg, valid_next;
    point_t pt_reg;

    logic signed [COORD_BITS+1:0]  dx, dy;
    logic signed [STEP_W:0]        sx, sy;
    logic signed [COORD_BITS+STEP_W+2:0] px, py;
    logic signed [SAT_W-1:0]       ex, ey;
    logic                          accept;

    assign dx = $signed({2'b00, pixel_x})
              - $signed({1'b0, cfg.image_width[SIZE_W-1:1]});
    assign dy = $signed({2'b00, pixel_y})
              - $signed({1'b0, cfg.image_height[SIZE_W-1:1]});
    assign sx = $signed({1'b0, cfg.step_x});
    assign sy = $signed({1'b0, cfg.step_y});
    assign px = dx * sx;
    assign py = dy * sy;
    assign ex = SAT_W'(px) + SAT_W'(cfg.offset_x);
    assign ey = SAT_W'(py) + SAT_W'(cfg.offset_y);

    assign s_tready = !valid_reg || pt_ready;
    assign accept   = s_tvalid && s_tready;
    assign pt_valid = valid_reg;
    assign pt_data  = pt_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (pt_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_reg.cx <= sat_val(ex);
            pt_reg.cy <= sat_val(ey);
        end
    end

endmodule

>>> hw/rtl/mpe_queue.sv
// ----------------------------------------------------------------------------
// mpe_queue
// Small FIFO of mapped points between the front end and the iteration engine.
// ----------------------------------------------------------------------------
module mpe_queue
    import mpe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output point_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    point_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> hw/rtl/mpe_back.sv
// ----------------------------------------------------------------------------
// mpe_back
// Iterates z = z^2 + c on one shared multiplier, then derives the color of an escaped pixel.
// ----------------------------------------------------------------------------
module mpe_back
    import mpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ITER_W-1:0] max_iter,
    input  logic              pt_valid,
    output logic              pt_ready,
    input  point_t            pt_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic              m_tuser
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_XX   = 4'd1;
    localparam logic [3:0] ST_YY   = 4'd2;
    localparam logic [3:0] ST_XY   = 4'd3;
    localparam logic [3:0] ST_TEST = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_COL  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam logic [VAL_W-1:0] FOUR = VAL_W'(4) << FRAC_BITS;
    localparam logic [16:0]      ONE_Q16 = 17'h10000;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [1:0]        ch_reg, ch_next;
    logic [1:0]        sub_reg, sub_next;
    logic              ovalid_reg, ovalid_next;

    val_t              cx_reg, cy_reg, zx_reg, zy_reg;
    mag_t              xx_reg, yy_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic [ITER_W-1:0] n_reg, rem_reg, tq_reg;
    logic [16:0]       cur_reg, pr_reg, pg_reg, pb_reg;
    logic [7:0]        red_reg, green_reg, blue_reg;
    logic [7:0]        ored_reg, ogreen_reg, oblue_reg;
    logic [ITER_W-1:0] ocount_reg;
    logic              oin_reg, inside_reg;

    // Multiplier operands and the products of the test step.
    logic [VAL_W-1:0]  mag_x, mag_y, mul_a, mul_b;
    mag_t              xy_mag;
    logic              xy_neg;
    logic [VAL_W-1:0]  sumsq;
    logic              go_on;
    logic signed [SAT_W-1:0] nx_w, xy2_w, ny_w;
    logic [16:0]       r2;
    logic              qbit;
    logic [16:0]       tv, uv, ca, cb, cres;
    logic [33:0]       cprod;
    logic [28:0]       rp, gp, bp;
    logic              load_out;

    assign mag_x = zx_reg[VAL_W-1] ? VAL_W'(-zx_reg) : VAL_W'(zx_reg);
    assign mag_y = zy_reg[VAL_W-1] ? VAL_W'(-zy_reg) : VAL_W'(zy_reg);

    always_comb
    begin
        case (state_reg)
            ST_XX:
            begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
            ST_YY:
            begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            default:
            begin
                mul_a = mag_x;
                mul_b = mag_y;
            end
        endcase
    end

    assign xy_mag = fix_mag(prod_reg);
    assign xy_neg = zx_reg[VAL_W-1] ^ zy_reg[VAL_W-1];
    assign sumsq  = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign go_on  = (sumsq < FOUR) && (n_reg < max_iter);
    assign nx_w   = SAT_W'($signed({1'b0, xx_reg})) - SAT_W'($signed({1'b0, yy_reg}))
                  + SAT_W'(cx_reg);
    assign xy2_w  = SAT_W'($signed({1'b0, xy_mag, 1'b0}));
    assign ny_w   = (xy_neg ? -xy2_w : xy2_w) + SAT_W'(cy_reg);

    // Restoring division step for t = count * 2^16 / max_iter.
    assign r2   = {rem_reg, 1'b0};
    assign qbit = (r2 >= {1'b0, max_iter});

    // Color chain: red t*t*t*u, green t*t*u*u, blue t*u*u*u in Q0.16.
    assign tv = {1'b0, tq_reg};
    assign uv = ONE_Q16 - tv;
    assign ca = (sub_reg == 2'd0) ? tv : cur_reg;

    always_comb
    begin
        case (sub_reg)
            2'd0:    cb = (ch_reg == 2'd2) ? uv : tv;
            2'd1:    cb = (ch_reg == 2'd0) ? tv : uv;
            default: cb = uv;
        endcase
    end

    assign cprod = ca * cb;
    assign cres  = cprod[32:16];
    assign rp    = 29'(pr_reg) * 29'd2295;
    assign gp    = 29'(pg_reg) * 29'd3825;
    assign bp    = 29'(pb_reg) * 29'd4335;

    assign pt_ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_OUT) && (!ovalid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ch_next     = ch_reg;
        sub_next    = sub_reg;
        ovalid_next = ovalid_reg;
        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pt_valid)
                begin
                    state_next = ST_XX;
                end
            end
            ST_XX:   state_next = ST_YY;
            ST_YY:   state_next = ST_XY;
            ST_XY:   state_next = ST_TEST;
            ST_TEST:
            begin
                if (go_on)
                begin
                    state_next = ST_XX;
                end
                else if (n_reg == max_iter)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_COL;
                    ch_next    = '0;
                    sub_next   = '0;
                end
            end
            ST_COL:
            begin
                if (sub_reg == 2'd2)
                begin
                    sub_next = '0;
                    ch_next  = ch_reg + 1'b1;
                    if (ch_reg == 2'd2)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 1'b1;
                end
            end
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (load_out)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ch_reg     <= '0;
            sub_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ch_reg     <= ch_next;
            sub_reg    <= sub_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                cx_reg <= pt_data.cx;
                cy_reg <= pt_data.cy;
                zx_reg <= '0;
                zy_reg <= '0;
                n_reg  <= '0;
            end
            ST_YY:   xx_reg <= fix_mag(prod_reg);
            ST_XY:   yy_reg <= fix_mag(prod_reg);
            ST_TEST:
            begin
                rem_reg    <= n_reg;
                inside_reg <= 1'b1;
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
                if (go_on)
                begin
                    zx_reg <= sat_val(nx_w);
                    zy_reg <= sat_val(ny_w);
                    n_reg  <= n_reg + 1'b1;
                end
                else if (n_reg != max_iter)
                begin
                    inside_reg <= 1'b0;
                end
            end
            ST_DIV:
            begin
                rem_reg <= qbit ? ITER_W'(r2 - {1'b0, max_iter}) : r2[ITER_W-1:0];
                tq_reg  <= {tq_reg[ITER_W-2:0], qbit};
            end
            ST_COL:
            begin
                cur_reg <= cres;
                if (sub_reg == 2'd2)
                begin
                    case (ch_reg)
                        2'd0:    pr_reg <= cres;
                        2'd1:    pg_reg <= cres;
                        default: pb_reg <= cres;
                    endcase
                end
            end
            ST_FIN:
            begin
                red_reg   <= (rp[28:16] > 13'd255) ? 8'hff : rp[23:16];
                green_reg <= (gp[28:16] > 13'd255) ? 8'hff : gp[23:16];
                blue_reg  <= (bp[28:17] > 12'd255) ? 8'hff : bp[24:17];
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            ored_reg   <= red_reg;
            ogreen_reg <= green_reg;
            oblue_reg  <= blue_reg;
            ocount_reg <= n_reg;
            oin_reg    <= inside_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {ocount_reg, oblue_reg, ogreen_reg, ored_reg};
    assign m_tuser  = oin_reg;

endmodule

>>> hw/rtl/mandelbrot_pixel_escape_color.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_color
// Escape-time Mandelbrot pixel engine with a colored result per pixel.
// ----------------------------------------------------------------------------
// Each request names one pixel (column, row). The front end maps it to the point
// c = offset + (pixel - size/2) * step in signed Q4.28, registers it and parks
// it in a short queue, so new pixels are taken while the engine is busy.
// The back end iterates z = z^2 + c on one shared 32 x 32 multiplier; each
// iteration steps through x^2, y^2, x*y, then the escape test and update. A
// pixel that escapes after n iterations then passes through the bit-serial
// division for t = n/max_iter, the color products and the final scaling to
// bytes; a pixel that reaches max_iter comes out black with in_set set. The
// default limit is 500; the iteration loop on the shared multiplier sets the
// rate. Results leave through a registered output stage in request order.
// Configuration registers should only be written while no request is in
// flight.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_color
    import mpe_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Pixel requests.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // pixel_x [11:0], pixel_y [23:12]
    // Colored results.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // red, green, blue, escape_count [39:24]
    output logic              m_tuser    // in_set
);

    cfg_t   cfg_reg;
    logic   wr_en;
    logic   pt_valid, pt_ready, q_valid, q_ready;
    point_t pt_data, q_data;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register file. Only the low bits of each write are kept; the offsets are
    // stored as full 32-bit signed values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 13'd1920;
            cfg_reg.image_height <= 13'd1080;
            cfg_reg.max_iter     <= 16'd500;
            cfg_reg.offset_x     <= -32'sd134217728;
            cfg_reg.offset_y     <= '0;
            cfg_reg.step_x       <= 29'd419430;
            cfg_reg.step_y       <= 29'd497103;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[SIZE_W-1:0];
                REG_MAX_ITER:     cfg_reg.max_iter     <= pwdata[ITER_W-1:0];
                REG_OFFSET_X:     cfg_reg.offset_x     <= pwdata;
                REG_OFFSET_Y:     cfg_reg.offset_y     <= pwdata;
                REG_STEP_X:       cfg_reg.step_x       <= pwdata[STEP_W-1:0];
                REG_STEP_Y:       cfg_reg.step_y       <= pwdata[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            REG_MAX_ITER:     prdata = 32'(cfg_reg.max_iter);
            REG_OFFSET_X:     prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:     prdata = cfg_reg.offset_y;
            REG_STEP_X:       prdata = 32'(cfg_reg.step_x);
            REG_STEP_Y:       prdata = 32'(cfg_reg.step_y);
            default:          prdata = '0;
        endcase
    end

    mpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .pixel_x  (s_tdata[11:0]),
        .pixel_y  (s_tdata[23:12]),
        .pt_valid (pt_valid),
        .pt_ready (pt_ready),
        .pt_data  (pt_data)
    );

    mpe_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pt_valid),
        .in_ready  (pt_ready),
        .in_data   (pt_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    mpe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_iter (cfg_reg.max_iter),
        .pt_valid (q_valid),
        .pt_ready (q_ready),
        .pt_data  (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hw/rtl/mpe_checker.sv
// ----------------------------------------------------------------------------
// mpe_checker
// Port-level checks on the escape-time engine, bound to its top level.
// ----------------------------------------------------------------------------
module mpe_checker
    import mpe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [39:0]       m_tdata,
    input logic              m_tuser
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Points inside the set are black.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0)
        else $error("in-set pixel is not black");

    // An escaped pixel with no iterations has t = 0 and therefore no color.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && m_tdata[39:24] == 16'd0 |-> m_tdata[23:0] == 24'd0)
        else $error("zero count gave a color");

    // The register port never inserts wait states.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind mandelbrot_pixel_escape_color mpe_checker u_mpe_checker (.*);
